>>> src/swfr_pkg.sv
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared constants and types of the stop-and-wait frame receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned ApbDW   = 32;
  localparam int unsigned ApbAW   = 5;
  localparam int unsigned RegIdxW = 3;

  localparam logic [ByteW-1:0] FLAG_BYTE       = 8'h7E;
  localparam logic [ByteW-1:0] ESC_BYTE        = 8'h7D;
  localparam logic [ByteW-1:0] ESC_FOR_ESC     = 8'h5D;
  localparam logic [ByteW-1:0] ESC_FOR_FLAG    = 8'h5E;
  localparam logic [ByteW-1:0] SEQ_ONE_CTRL    = 8'h40;
  localparam logic [ByteW-1:0] SEQ_ZERO_CTRL   = 8'h00;
  localparam logic [ByteW-1:0] UNKNOWN_ESC_XOR = 8'h20;

  localparam logic [KindW-1:0] KIND_DATA   = 2'd0;
  localparam logic [KindW-1:0] KIND_ACCEPT = 2'd1;
  localparam logic [KindW-1:0] KIND_REJECT = 2'd2;
  localparam logic [KindW-1:0] KIND_DUP    = 2'd3;

  localparam logic [RegIdxW-1:0] REG_SENDER_ADDR   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_RECEIVER_ADDR = 3'd1;
  localparam logic [RegIdxW-1:0] REG_READY_ZERO    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_READY_ONE     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_REJECT_ZERO   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_REJECT_ONE    = 3'd5;

  localparam logic [ByteW-1:0] RST_SENDER_ADDR   = 8'd3;
  localparam logic [ByteW-1:0] RST_RECEIVER_ADDR = 8'd1;
  localparam logic [ByteW-1:0] RST_READY_ZERO    = 8'd5;
  localparam logic [ByteW-1:0] RST_READY_ONE     = 8'd133;
  localparam logic [ByteW-1:0] RST_REJECT_ZERO   = 8'd1;
  localparam logic [ByteW-1:0] RST_REJECT_ONE    = 8'd129;

  typedef struct packed {
    logic [ByteW-1:0] sender_address;
    logic [ByteW-1:0] receiver_address;
    logic [ByteW-1:0] ready_zero_code;
    logic [ByteW-1:0] ready_one_code;
    logic [ByteW-1:0] reject_zero_code;
    logic [ByteW-1:0] reject_one_code;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] reply_control;
    logic [ByteW-1:0] reply_check;
    logic             seq_after;
  } result_t;

endpackage

>>> src/stop_and_wait_frame_receiver.sv
// A transferred byte is held in the input byte register, and its result, if it has one,
// is then registered in the result register before it can transfer.
// Throughput: one byte per cycle; the result register stalls the input only when full
// and not taken.
// Reset: asynchronous, active low; the valid flags, settings and receiver state return to
// their defaults, and the receiver hunts for an opening flag with sequence bit zero.
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver
// Byte-stuffed stop-and-wait frame receiver with RR / REJ reply generation.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_receiver
  import swfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAW-1:0] paddr,
  input  logic [ApbDW-1:0] pwdata,
  output logic [ApbDW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KindW-1:0] kind_o,
  output logic [ByteW-1:0] data_byte_o,
  output logic [ByteW-1:0] reply_control_o,
  output logic [ByteW-1:0] reply_check_o,
  output logic             seq_after_o
);

  cfg_t             cfg;
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q, out_vld_d;
  result_t          res_q, res;
  logic             advance, emit;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  swfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swfr_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
    out_vld_d = out_vld_q && !out_ready_i;
    if (advance) begin
      out_vld_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = res_q.kind;
  assign data_byte_o     = res_q.data_byte;
  assign reply_control_o = res_q.reply_control;
  assign reply_check_o   = res_q.reply_check;
  assign seq_after_o     = res_q.seq_after;

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q))
    else $error("input register lost a byte while stalled");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_o == KIND_DATA |-> reply_control_o == '0 && reply_check_o == '0)
    else $error("payload result carries reply fields");

  a_reply_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_o != KIND_DATA |->
      data_byte_o == '0 && reply_check_o == (reply_control_o ^ cfg.receiver_address))
    else $error("reply result malformed");

  a_no_step_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !advance)
    else $error("byte processed while result register full");
`endif

endmodule

>>> src/swfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// swfr_cfg_regs
// APB register file holding addresses and reply control codes.
// ----------------------------------------------------------------------------
module swfr_cfg_regs
  import swfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAW-1:0] paddr,
  input  logic [ApbDW-1:0] pwdata,
  output logic [ApbDW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t               cfg_q;
  logic [RegIdxW-1:0] idx;
  logic               wr_en;
  logic [ByteW-1:0]   rd_byte;

  assign idx    = paddr[ApbAW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sender_address   <= RST_SENDER_ADDR;
      cfg_q.receiver_address <= RST_RECEIVER_ADDR;
      cfg_q.ready_zero_code  <= RST_READY_ZERO;
      cfg_q.ready_one_code   <= RST_READY_ONE;
      cfg_q.reject_zero_code <= RST_REJECT_ZERO;
      cfg_q.reject_one_code  <= RST_REJECT_ONE;
    end else if (wr_en) begin
      case (idx)
        REG_SENDER_ADDR:   cfg_q.sender_address   <= pwdata[ByteW-1:0];
        REG_RECEIVER_ADDR: cfg_q.receiver_address <= pwdata[ByteW-1:0];
        REG_READY_ZERO:    cfg_q.ready_zero_code  <= pwdata[ByteW-1:0];
        REG_READY_ONE:     cfg_q.ready_one_code   <= pwdata[ByteW-1:0];
        REG_REJECT_ZERO:   cfg_q.reject_zero_code <= pwdata[ByteW-1:0];
        REG_REJECT_ONE:    cfg_q.reject_one_code  <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SENDER_ADDR:   rd_byte = cfg_q.sender_address;
      REG_RECEIVER_ADDR: rd_byte = cfg_q.receiver_address;
      REG_READY_ZERO:    rd_byte = cfg_q.ready_zero_code;
      REG_READY_ONE:     rd_byte = cfg_q.ready_one_code;
      REG_REJECT_ZERO:   rd_byte = cfg_q.reject_zero_code;
      REG_REJECT_ONE:    rd_byte = cfg_q.reject_one_code;
      default:           rd_byte = '0;
    endcase
  end

  assign prdata = {{(ApbDW-ByteW){1'b0}}, rd_byte};
  assign cfg_o  = cfg_q;

endmodule

>>> src/swfr_frame_fsm.sv
// ----------------------------------------------------------------------------
// swfr_frame_fsm
// Header hunt, destuffing, payload check and reply selection for one byte.
// ----------------------------------------------------------------------------
module swfr_frame_fsm
  import swfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output logic             emit_o,
  output result_t          res_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_DATA
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             seq_q, seq_d;
  logic             esc_q, esc_d;
  logic [1:0]       seen_q, seen_d;
  logic [ByteW-1:0] held_q, held_d;
  logic [ByteW-1:0] xor_q, xor_d;

  logic [ByteW-1:0] b, expected, other, dbyte, ctrl;
  logic             do_deliver, ok, reply;

  assign b        = rx_byte_i;
  assign expected = seq_q ? SEQ_ONE_CTRL : SEQ_ZERO_CTRL;
  assign other    = seq_q ? SEQ_ZERO_CTRL : SEQ_ONE_CTRL;

  always_comb begin
    phase_d    = phase_q;
    seq_d      = seq_q;
    esc_d      = esc_q;
    seen_d     = seen_q;
    held_d     = held_q;
    xor_d      = xor_q;
    do_deliver = 1'b0;
    dbyte      = b;
    ok         = 1'b0;
    reply      = 1'b0;
    ctrl       = '0;
    emit_o     = 1'b0;
    res_o      = '0;
    case (phase_q)
      PH_FLAG: begin
        if (b == FLAG_BYTE) begin
          phase_d = PH_FLAG;
        end else if (b == cfg_i.sender_address) begin
          phase_d = PH_ADDR;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_ADDR: begin
        if (b == FLAG_BYTE) begin
          phase_d = PH_FLAG;
        end else if (b == expected) begin
          phase_d = PH_CTRL;
        end else if (b == other) begin
          phase_d    = PH_HUNT;
          reply      = 1'b1;
          res_o.kind = KIND_DUP;
          ctrl       = seq_q ? cfg_i.ready_zero_code : cfg_i.ready_one_code;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (b == FLAG_BYTE) begin
          phase_d = PH_FLAG;
        end else if (b == (cfg_i.sender_address ^ expected)) begin
          phase_d = PH_DATA;
          esc_d   = 1'b0;
          seen_d  = '0;
          held_d  = '0;
          xor_d   = '0;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (b == FLAG_BYTE) begin
          phase_d = PH_HUNT;
          esc_d   = 1'b0;
          if (seen_q == 2'd0 || esc_q) begin
            ok = 1'b0;
          end else if (seen_q == 2'd1) begin
            ok = 1'b1;
          end else begin
            ok = (held_q == xor_q);
          end
          reply = 1'b1;
          if (ok) begin
            res_o.kind = KIND_ACCEPT;
            ctrl       = seq_q ? cfg_i.ready_zero_code : cfg_i.ready_one_code;
            seq_d      = ~seq_q;
          end else begin
            res_o.kind = KIND_REJECT;
            ctrl       = seq_q ? cfg_i.reject_one_code : cfg_i.reject_zero_code;
          end
        end else if (esc_q) begin
          esc_d      = 1'b0;
          do_deliver = 1'b1;
          if (b == ESC_FOR_ESC) begin
            dbyte = ESC_BYTE;
          end else if (b == ESC_FOR_FLAG) begin
            dbyte = FLAG_BYTE;
          end else begin
            dbyte = b ^ UNKNOWN_ESC_XOR;
          end
        end else if (b == ESC_BYTE) begin
          esc_d = 1'b1;
        end else begin
          do_deliver = 1'b1;
        end
      end
      default: begin
        if (b == FLAG_BYTE) begin
          phase_d = PH_FLAG;
        end
      end
    endcase

    if (reply) begin
      emit_o              = 1'b1;
      res_o.reply_control = ctrl;
      res_o.reply_check   = cfg_i.receiver_address ^ ctrl;
    end

    if (do_deliver) begin
      if (seen_q != 2'd0) begin
        emit_o          = 1'b1;
        res_o.kind      = KIND_DATA;
        res_o.data_byte = held_q;
        xor_d           = xor_q ^ held_q;
      end
      held_d = dbyte;
      if (seen_q != 2'd2) begin
        seen_d = seen_q + 2'd1;
      end
    end

    res_o.seq_after = seq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      seq_q   <= 1'b0;
      esc_q   <= 1'b0;
      seen_q  <= '0;
      held_q  <= '0;
      xor_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      esc_q   <= esc_d;
      seen_q  <= seen_d;
      held_q  <= held_d;
      xor_q   <= xor_d;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stop-and-wait frame receiver. Line bytes are
// fed from a queue over valid/ready, with random sender gaps and receiver
// stalls. A behavioural decoder predicts every payload byte and RR / REJ
// reply, and each result transfer is compared field by field. Register
// settings are changed over APB between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  import swfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLDOFF_CYCLES = 300;

  localparam logic [RegIdxW-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [RegIdxW-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_DATA
  } rx_phase_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [ApbAW-1:0] paddr       = '0;
  logic [ApbDW-1:0] pwdata      = '0;
  logic [ApbDW-1:0] prdata;
  logic             pready;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] rx_byte_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [KindW-1:0] kind_o;
  logic [ByteW-1:0] data_byte_o;
  logic [ByteW-1:0] reply_control_o;
  logic [ByteW-1:0] reply_check_o;
  logic             seq_after_o;

  stop_and_wait_frame_receiver u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .reply_control_o(reply_control_o),
    .reply_check_o  (reply_check_o),
    .seq_after_o    (seq_after_o)
  );

  // line bytes waiting to be offered, and results the decoder expects
  logic [ByteW-1:0] line_bytes [$];
  result_t          frame_results [$];

  int unsigned items_queued    = 0;
  int unsigned items_accepted  = 0;
  int unsigned mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned rx_stall_pct    = 0;
  logic        in_taken        = 1'b0;
  logic        hold_rx         = 1'b0;
  logic        holdoff_go      = 1'b0;
  logic        gen_seq         = 1'b0;

  // decoder state and its copy of the registers
  cfg_t             model_cfg;
  rx_phase_e        hdr_phase;
  logic             seq_bit;
  logic             esc_open;
  logic [1:0]       bytes_seen;
  logic [ByteW-1:0] held_byte;
  logic [ByteW-1:0] run_xor;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [ByteW-1:0] got,
                                 input logic [ByteW-1:0] want);
    if (mismatch_count < 40) begin
      $display("[%0t] mismatch on %s: got %02h, want %02h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic push_reply(input logic [KindW-1:0] k, input logic [ByteW-1:0] ctrl);
    result_t r;
    r.kind          = k;
    r.data_byte     = '0;
    r.reply_control = ctrl;
    r.reply_check   = model_cfg.receiver_address ^ ctrl;
    r.seq_after     = seq_bit;
    frame_results.push_back(r);
  endtask

  // emit the held byte one step late; the last one of a frame is the check
  task automatic deliver_payload(input logic [ByteW-1:0] d);
    result_t r;
    if (bytes_seen != 2'd0) begin
      r.kind          = KIND_DATA;
      r.data_byte     = held_byte;
      r.reply_control = '0;
      r.reply_check   = '0;
      r.seq_after     = seq_bit;
      frame_results.push_back(r);
      run_xor = run_xor ^ held_byte;
    end
    held_byte = d;
    if (bytes_seen < 2'd2) bytes_seen = bytes_seen + 2'd1;
  endtask

  task automatic decode_line_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] want_ctrl;
    logic [ByteW-1:0] other_ctrl;
    logic             ok;
    want_ctrl  = seq_bit ? SEQ_ONE_CTRL : SEQ_ZERO_CTRL;
    other_ctrl = seq_bit ? SEQ_ZERO_CTRL : SEQ_ONE_CTRL;
    case (hdr_phase)
      PH_FLAG: begin
        if (b == FLAG_BYTE) hdr_phase = PH_FLAG;
        else if (b == model_cfg.sender_address) hdr_phase = PH_ADDR;
        else hdr_phase = PH_HUNT;
      end
      PH_ADDR: begin
        if (b == FLAG_BYTE) begin
          hdr_phase = PH_FLAG;
        end else if (b == want_ctrl) begin
          hdr_phase = PH_CTRL;
        end else if (b == other_ctrl) begin
          hdr_phase = PH_HUNT;
          push_reply(KIND_DUP, seq_bit ? model_cfg.ready_zero_code : model_cfg.ready_one_code);
        end else begin
          hdr_phase = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (b == FLAG_BYTE) begin
          hdr_phase = PH_FLAG;
        end else if (b == (model_cfg.sender_address ^ want_ctrl)) begin
          hdr_phase  = PH_DATA;
          esc_open   = 1'b0;
          bytes_seen = 2'd0;
          held_byte  = '0;
          run_xor    = '0;
        end else begin
          hdr_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (b == FLAG_BYTE) begin
          hdr_phase = PH_HUNT;
          if (bytes_seen == 2'd0 || esc_open) ok = 1'b0;
          else if (bytes_seen == 2'd1) ok = 1'b1;
          else ok = (held_byte == run_xor);
          esc_open = 1'b0;
          if (ok) begin
            seq_bit = ~seq_bit;
            push_reply(KIND_ACCEPT,
                       seq_bit ? model_cfg.ready_one_code : model_cfg.ready_zero_code);
          end else begin
            push_reply(KIND_REJECT,
                       seq_bit ? model_cfg.reject_one_code : model_cfg.reject_zero_code);
          end
        end else if (esc_open) begin
          esc_open = 1'b0;
          if (b == ESC_FOR_ESC) deliver_payload(ESC_BYTE);
          else if (b == ESC_FOR_FLAG) deliver_payload(FLAG_BYTE);
          else deliver_payload(b ^ UNKNOWN_ESC_XOR);
        end else if (b == ESC_BYTE) begin
          esc_open = 1'b1;
        end else begin
          deliver_payload(b);
        end
      end
      default: begin
        if (b == FLAG_BYTE) hdr_phase = PH_FLAG;
      end
    endcase
  endtask

  // drive: hold an offered byte until its transfer, else offer the next one
  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
    end else if (line_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      in_valid_i <= 1'b1;
      rx_byte_i  <= line_bytes.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= hold_rx ? 1'b0 : ($urandom_range(0, 99) >= rx_stall_pct);
  end

  initial begin
    wait (holdoff_go);
    hold_rx = 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // sample: check result transfers, then predict from byte transfers
  always @(posedge clk_i) begin : monitor_blk
    result_t got;
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("stop_and_wait_frame_receiver verification failed");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.kind          = kind_o;
        got.data_byte     = data_byte_o;
        got.reply_control = reply_control_o;
        got.reply_check   = reply_check_o;
        got.seq_after     = seq_after_o;
        if (frame_results.size() == 0) begin
          report_mismatch("result with nothing pending", ByteW'(got.kind), '0);
        end else begin
          want = frame_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("kind", ByteW'(got.kind), ByteW'(want.kind));
          if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", got.data_byte, want.data_byte);
          if (got.reply_control !== want.reply_control)
            report_mismatch("reply_control", got.reply_control, want.reply_control);
          if (got.reply_check !== want.reply_check)
            report_mismatch("reply_check", got.reply_check, want.reply_check);
          if (got.seq_after !== want.seq_after)
            report_mismatch("seq_after", ByteW'(got.seq_after), ByteW'(want.seq_after));
        end
      end
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        items_accepted++;
        decode_line_byte(rx_byte_i);
      end
    end
  end

  task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [ByteW-1:0] v);
    logic [ApbDW-1:0] w;
    w = $urandom();
    w[ByteW-1:0] = v;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= w;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_SENDER_ADDR:   model_cfg.sender_address   = v;
      REG_RECEIVER_ADDR: model_cfg.receiver_address = v;
      REG_READY_ZERO:    model_cfg.ready_zero_code  = v;
      REG_READY_ONE:     model_cfg.ready_one_code   = v;
      REG_REJECT_ZERO:   model_cfg.reject_zero_code = v;
      REG_REJECT_ONE:    model_cfg.reject_one_code  = v;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_config(input cfg_t c);
    apb_write(REG_SENDER_ADDR, c.sender_address);
    apb_write(REG_RECEIVER_ADDR, c.receiver_address);
    apb_write(REG_READY_ZERO, c.ready_zero_code);
    apb_write(REG_READY_ONE, c.ready_one_code);
    apb_write(REG_REJECT_ZERO, c.reject_zero_code);
    apb_write(REG_REJECT_ONE, c.reject_one_code);
    apb_write($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, ByteW'($urandom()));
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.sender_address   = ByteW'($urandom());
    c.receiver_address = ByteW'($urandom());
    c.ready_zero_code  = ByteW'($urandom());
    c.ready_one_code   = ByteW'($urandom());
    c.reject_zero_code = ByteW'($urandom());
    c.reject_one_code  = ByteW'($urandom());
    // keep every header reachable
    while (c.sender_address == FLAG_BYTE || (c.sender_address ^ SEQ_ONE_CTRL) == FLAG_BYTE)
      c.sender_address = ByteW'($urandom());
    return c;
  endfunction

  task automatic wait_idle();
    while (items_accepted != items_queued || frame_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    gen_seq = seq_bit;
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b);
    line_bytes.push_back(b);
    items_queued++;
  endtask

  function automatic logic [ByteW-1:0] random_line_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom());
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: b = FLAG_BYTE;
        1: b = ESC_BYTE;
        2: b = ESC_FOR_ESC;
        default: b = ESC_FOR_FLAG;
      endcase
    end
    return b;
  endfunction

  task automatic push_stuffed(input logic [ByteW-1:0] d);
    if (d == FLAG_BYTE) begin
      push_byte(ESC_BYTE);
      push_byte(ESC_FOR_FLAG);
    end else if (d == ESC_BYTE) begin
      push_byte(ESC_BYTE);
      push_byte(ESC_FOR_ESC);
    end else if (d != ESC_FOR_FLAG && $urandom_range(0, 9) == 0) begin
      push_byte(ESC_BYTE);
      push_byte(d ^ UNKNOWN_ESC_XOR);
    end else begin
      push_byte(d);
    end
  endtask

  task automatic push_frame();
    logic [ByteW-1:0] ctrl;
    logic [ByteW-1:0] hdr;
    logic [ByteW-1:0] d;
    logic [ByteW-1:0] chk;
    int unsigned      sel;
    int unsigned      n;
    sel = $urandom_range(0, 99);
    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    if (sel >= 88) begin
      repeat ($urandom_range(1, 6)) push_byte(random_line_byte());
    end else begin
      ctrl = gen_seq ? SEQ_ONE_CTRL : SEQ_ZERO_CTRL;
      push_byte(FLAG_BYTE);
      if ($urandom_range(0, 9) == 0) push_byte(FLAG_BYTE);
      if (sel >= 68 && sel < 72) begin
        push_byte(model_cfg.sender_address ^ (8'h01 << $urandom_range(0, 7)));
      end else begin
        push_byte(model_cfg.sender_address);
        if (sel >= 85) begin
          if ($urandom_range(0, 1) != 0) push_byte(ctrl);
          push_byte(FLAG_BYTE);
          push_byte(model_cfg.sender_address);
        end
        if (sel >= 63 && sel < 68) ctrl = ctrl ^ SEQ_ONE_CTRL;
        push_byte(ctrl);
        hdr = model_cfg.sender_address ^ ctrl;
        if (sel >= 72 && sel < 75) hdr = hdr ^ (8'h01 << $urandom_range(0, 7));
        push_byte(hdr);
      end
      if (sel >= 75 && sel < 78) begin
      end else if (sel >= 78 && sel < 81) begin
        repeat (n) push_stuffed(random_line_byte());
        push_byte(ESC_BYTE);
      end else if (sel >= 81 && sel < 85) begin
        push_stuffed(random_line_byte());
      end else begin
        chk = '0;
        repeat (n) begin
          d   = random_line_byte();
          chk = chk ^ d;
          push_stuffed(d);
        end
        if (sel >= 55 && sel < 63) chk = chk ^ (8'h01 << $urandom_range(0, 7));
        push_stuffed(chk);
      end
      push_byte(FLAG_BYTE);
      if (sel < 55 || (sel >= 81 && sel < 88)) gen_seq = ~gen_seq;
    end
  endtask

  task automatic fill_frames(input int unsigned count);
    int unsigned target;
    target = items_queued + count;
    while (items_queued < target) push_frame();
  endtask

  initial begin
    logic [ByteW-1:0] opening [$];
    cfg_t             c;
    model_cfg = {RST_SENDER_ADDR, RST_RECEIVER_ADDR, RST_READY_ZERO, RST_READY_ONE,
                 RST_REJECT_ZERO, RST_REJECT_ONE};
    hdr_phase  = PH_HUNT;
    seq_bit    = 1'b0;
    esc_open   = 1'b0;
    bytes_seen = 2'd0;
    held_byte  = '0;
    run_xor    = '0;
    opening = '{8'h00, 8'hFF, FLAG_BYTE, FLAG_BYTE, RST_SENDER_ADDR, SEQ_ZERO_CTRL,
                RST_SENDER_ADDR ^ SEQ_ZERO_CTRL, ESC_BYTE, ESC_FOR_FLAG, ESC_BYTE,
                ESC_FOR_ESC, ESC_BYTE, 8'h41, 8'h62, FLAG_BYTE,
                FLAG_BYTE, RST_SENDER_ADDR, SEQ_ONE_CTRL, RST_SENDER_ADDR ^ SEQ_ONE_CTRL,
                FLAG_BYTE, FLAG_BYTE, RST_SENDER_ADDR, SEQ_ZERO_CTRL};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, no idling
    foreach (opening[i]) push_byte(opening[i]);
    wait_idle();
    fill_frames(150);
    wait_idle();

    // all registers at zero, sender idles
    load_config('0);
    sender_idle_pct = 55;
    fill_frames(200);
    wait_idle();

    // all registers at their maximum, receiver stalls
    load_config('1);
    sender_idle_pct = 0;
    rx_stall_pct    = 55;
    fill_frames(200);
    wait_idle();

    c = random_config();
    load_config(c);
    sender_idle_pct = 33;
    rx_stall_pct    = 33;
    fill_frames(200);
    wait_idle();

    // long receiver hold-off while bytes keep coming
    c = random_config();
    load_config(c);
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    holdoff_go      = 1'b1;
    fill_frames(200);
    wait_idle();

    c = random_config();
    load_config(c);
    sender_idle_pct = 33;
    rx_stall_pct    = 33;
    fill_frames(200);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("stop_and_wait_frame_receiver verification clean");
    end else begin
      $display("stop_and_wait_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
